// File: hdl/ddp_pkg.sv
// shared types and constants for the dipole diffusion profile pipeline
// no dependencies; imported by every module of the block
package ddp_pkg;

  // default fixed point format
  localparam int unsigned DDP_FRAC_BITS  = 16;
  localparam int unsigned DDP_DATA_WIDTH = 32;

  // configuration port
  localparam int unsigned CFG_WIDTH     = 32;
  localparam int unsigned CFG_IDX_WIDTH = 2;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_REAL_DEPTH      = 2'd0,
    CFG_VIRTUAL_DEPTH   = 2'd1,
    CFG_TRANSPORT_COEFF = 2'd2,
    CFG_ALBEDO_SCALE    = 2'd3
  } cfg_idx_e;

  // register reset values, Q16.16
  localparam logic [CFG_WIDTH-1:0] RST_REAL_DEPTH      = 32'd65536;
  localparam logic [CFG_WIDTH-1:0] RST_VIRTUAL_DEPTH   = 32'd131072;
  localparam logic [CFG_WIDTH-1:0] RST_TRANSPORT_COEFF = 32'd65536;
  localparam logic [CFG_WIDTH-1:0] RST_ALBEDO_SCALE    = 32'd5215;

  // exponential unit, values in Q1.30
  localparam int unsigned EXP_BITS      = 30;
  localparam int unsigned EXP_TERMS     = 12;
  localparam int unsigned EXP_INT_LIMIT = 32;
  localparam int unsigned EXP_NW        = 5;

  typedef logic [EXP_BITS:0] exp_val_t;

  localparam exp_val_t EXP_ONE = exp_val_t'(1) << EXP_BITS;

  // number of chained divisions by the distance
  localparam int unsigned DDP_NUM_DIV = 3;

  // exponential pipeline stage contents
  typedef struct packed {
    exp_val_t          f;
    exp_val_t          acc;
    logic [EXP_NW-1:0] n;
    logic              big;
  } exp_st_t;

  // horner evaluation of exp(-f), only used at elaboration
  function automatic exp_val_t exp_frac_c(input exp_val_t f);
    logic [63:0] acc;
    logic [63:0] p;
    acc = 64'(EXP_ONE);
    for (int k = EXP_TERMS; k >= 1; k--) begin
      p   = (64'(f) * acc) >> EXP_BITS;
      acc = 64'(EXP_ONE) - p / 64'(k);
    end
    return acc[EXP_BITS:0];
  endfunction

  localparam exp_val_t EXP_E1 = exp_frac_c(EXP_ONE);

endpackage

// File: hdl/dipole_diffusion_profile.sv
// dipole diffusion reflectance, fully pipelined, one word accepted per cycle while the skid word is free
// the depth is set mostly by the pipelined square root, the exponential and the three restoring dividers
// a full output register and skid word stop the whole pipeline until drained
// reset clears all valid bits and loads the register defaults; no clearing pass
module dipole_diffusion_profile #(
  parameter int unsigned DATA_WIDTH = ddp_pkg::DDP_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = ddp_pkg::DDP_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [31:0]                   dist_squared_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [31:0]                   reflectance_o,
  input  logic                          cfg_we_i,
  input  logic [ddp_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [ddp_pkg::CFG_WIDTH-1:0] cfg_data_i
);
  import ddp_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned PW = 2 * W;

  localparam logic [W-1:0] MAXV = '1;

  // configuration registers
  logic [W-1:0] real_depth_q;
  logic [W-1:0] virtual_depth_q;
  logic [W-1:0] transport_coeff_q;
  logic [W-1:0] albedo_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_depth_q      <= W'(RST_REAL_DEPTH);
      virtual_depth_q   <= W'(RST_VIRTUAL_DEPTH);
      transport_coeff_q <= W'(RST_TRANSPORT_COEFF);
      albedo_scale_q    <= W'(RST_ALBEDO_SCALE);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_REAL_DEPTH:      real_depth_q      <= W'(cfg_data_i);
        CFG_VIRTUAL_DEPTH:   virtual_depth_q   <= W'(cfg_data_i);
        CFG_TRANSPORT_COEFF: transport_coeff_q <= W'(cfg_data_i);
        CFG_ALBEDO_SCALE:    albedo_scale_q    <= W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // pipeline advances while the skid word is free
  logic pipe_en;
  logic acc_in;
  logic out_valid_q;
  logic skid_valid_q;

  assign pipe_en    = !skid_valid_q;
  assign in_ready_o = pipe_en;
  assign acc_in     = in_valid_i && pipe_en;

  // real and virtual source lanes
  logic         t0_valid;
  logic         t1_valid;
  logic [W-1:0] t0_term;
  logic [W-1:0] t1_term;

  ddp_term #(
    .DATA_WIDTH (W),
    .FRAC_BITS  (FRAC_BITS)
  ) u_term_real (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (acc_in),
    .r2_i    (W'(dist_squared_i)),
    .depth_i (real_depth_q),
    .coeff_i (transport_coeff_q),
    .valid_o (t0_valid),
    .term_o  (t0_term)
  );

  ddp_term #(
    .DATA_WIDTH (W),
    .FRAC_BITS  (FRAC_BITS)
  ) u_term_virt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (acc_in),
    .r2_i    (W'(dist_squared_i)),
    .depth_i (virtual_depth_q),
    .coeff_i (transport_coeff_q),
    .valid_o (t1_valid),
    .term_o  (t1_term)
  );

  // sum of both terms, then albedo scaling
  logic [W:0]    sum_full;
  logic [W-1:0]  sum_d;
  logic          sum_valid_q;
  logic [W-1:0]  sum_q;
  logic [PW-1:0] res_prod;
  logic [PW-1:0] res_shr;
  logic [W-1:0]  res_d;
  logic          res_valid_q;
  logic [W-1:0]  res_q;

  assign sum_full = {1'b0, t0_term} + {1'b0, t1_term};
  assign sum_d    = sum_full[W] ? MAXV : sum_full[W-1:0];
  assign res_prod = PW'(albedo_scale_q) * PW'(sum_q);
  assign res_shr  = res_prod >> FRAC_BITS;
  assign res_d    = (|res_shr[PW-1:W]) ? MAXV : res_shr[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (pipe_en) begin
      sum_valid_q <= t0_valid;
      res_valid_q <= sum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sum_q <= sum_d;
      res_q <= res_d;
    end
  end

  // output register with one skid word
  logic         take;
  logic         out_valid_d;
  logic         skid_valid_d;
  logic [W-1:0] out_data_q;
  logic [W-1:0] out_data_d;
  logic [W-1:0] skid_data_q;
  logic [W-1:0] skid_data_d;

  assign take = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (take) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || take) begin
      out_valid_d = res_valid_q;
      out_data_d  = res_q;
    end else if (res_valid_q) begin
      skid_valid_d = 1'b1;
      skid_data_d  = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o   = out_valid_q;
  assign reflectance_o = 32'(out_data_q);

  // both source lanes stay in lockstep
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t0_valid == t1_valid)
    else $error("source term lanes out of step");

  // the skid word is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held with empty output register");

  // a taken output with a waiting skid word refills the output at once
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_ready_i |=> out_valid_o && !skid_valid_q)
    else $error("skid word not moved to output");

endmodule

// File: hdl/ddp_isqrt.sv
// pipelined integer square root, one root bit per stage
// depends on ddp_pkg for the default widths
module ddp_isqrt #(
  parameter int unsigned DATA_WIDTH = ddp_pkg::DDP_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = ddp_pkg::DDP_FRAC_BITS,
  parameter int unsigned ROOT_W     = (DATA_WIDTH + FRAC_BITS + 1) / 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [DATA_WIDTH-1:0] rad_i,
  output logic                  valid_o,
  output logic [ROOT_W-1:0]     root_o
);
  import ddp_pkg::*;

  localparam int unsigned XW  = 2 * ROOT_W;
  localparam int unsigned RMW = ROOT_W + 2;

  logic              v_q    [ROOT_W];
  logic [RMW-1:0]    rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [XW-1:0]     x_q    [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stg
    logic              v_in;
    logic [RMW-1:0]    rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [XW-1:0]     x_in;
    logic [RMW-1:0]    rem_sh;
    logic [RMW-1:0]    trial;
    logic [RMW-1:0]    rem_d;
    logic [ROOT_W-1:0] root_d;

    // stage input: radicand scaled by the fraction bits, or previous stage
    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = XW'({rad_i, {FRAC_BITS{1'b0}}});
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign x_in    = x_q[i-1];
    end

    // bring down one bit pair and try the next root bit
    always_comb begin
      rem_sh = {rem_in[RMW-3:0], x_in[XW-1 -: 2]};
      trial  = {root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d;
        root_q[i] <= root_d;
        x_q[i]    <= x_in << 2;
      end
    end
  end

  assign valid_o = v_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];

endmodule

// File: hdl/ddp_exp.sv
// pipelined exp(-t): horner series on the fraction, then one stage per
// possible multiply by exp(-1); depends on ddp_pkg
module ddp_exp #(
  parameter int unsigned DATA_WIDTH = ddp_pkg::DDP_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = ddp_pkg::DDP_FRAC_BITS,
  parameter int unsigned SB_WIDTH   = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [DATA_WIDTH-1:0] arg_i,
  input  logic [SB_WIDTH-1:0]   sb_i,
  output logic                  valid_o,
  output ddp_pkg::exp_val_t     exp_o,
  output logic [SB_WIDTH-1:0]   sb_o
);
  import ddp_pkg::*;

  localparam int unsigned NUM_HORNER = 2 * EXP_TERMS;
  localparam int unsigned NUM_POW    = EXP_INT_LIMIT - 1;
  localparam int unsigned NUM_STG    = 1 + NUM_HORNER + NUM_POW;

  logic                v_q  [NUM_STG];
  exp_st_t             st_q [NUM_STG];
  logic [SB_WIDTH-1:0] sb_q [NUM_STG];

  logic [DATA_WIDTH-1:0] int_part;

  assign int_part = arg_i >> FRAC_BITS;

  for (genvar i = 0; i < NUM_STG; i++) begin : g_stg
    logic                v_in;
    logic [SB_WIDTH-1:0] sb_in;
    exp_st_t             st_d;

    if (i == 0) begin : g_first
      // split the argument into integer count and Q1.30 fraction
      assign v_in  = valid_i;
      assign sb_in = sb_i;
      always_comb begin
        st_d.f   = exp_val_t'(arg_i[FRAC_BITS-1:0]) << (EXP_BITS - FRAC_BITS);
        st_d.acc = EXP_ONE;
        st_d.n   = int_part[EXP_NW-1:0];
        st_d.big = int_part >= DATA_WIDTH'(EXP_INT_LIMIT);
      end
    end else if (i <= NUM_HORNER) begin : g_horner
      localparam int unsigned J  = i - 1;
      localparam int unsigned K  = EXP_TERMS - J / 2;
      localparam int unsigned RS = EXP_BITS + 1 + $clog2(K);
      localparam logic [32:0] M  = 33'(((64'd1 << RS) + 64'(K) - 64'd1) / 64'(K));
      logic [63:0] prod;

      assign v_in  = v_q[i-1];
      assign sb_in = sb_q[i-1];
      if ((J % 2) == 0) begin : g_mul
        // f times the running sum
        assign prod = 64'(st_q[i-1].f) * 64'(st_q[i-1].acc);
        always_comb begin
          st_d     = st_q[i-1];
          st_d.acc = exp_val_t'(prod >> EXP_BITS);
        end
      end else begin : g_div
        // one minus the product over k, by reciprocal multiply
        assign prod = 64'(st_q[i-1].acc) * 64'(M);
        always_comb begin
          st_d     = st_q[i-1];
          st_d.acc = EXP_ONE - exp_val_t'(prod >> RS);
        end
      end
    end else begin : g_pow
      localparam int unsigned J = i - 1 - NUM_HORNER;
      logic [63:0] prod;

      // one factor of exp(-1) while the integer count allows
      assign v_in  = v_q[i-1];
      assign sb_in = sb_q[i-1];
      assign prod  = 64'(st_q[i-1].acc) * 64'(EXP_E1);
      always_comb begin
        st_d = st_q[i-1];
        if (st_q[i-1].n > EXP_NW'(J)) begin
          st_d.acc = exp_val_t'(prod >> EXP_BITS);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i] <= st_d;
        sb_q[i] <= sb_in;
      end
    end
  end

  // large arguments underflow to zero
  assign valid_o = v_q[NUM_STG-1];
  assign exp_o   = st_q[NUM_STG-1].big ? '0 : st_q[NUM_STG-1].acc;
  assign sb_o    = sb_q[NUM_STG-1];

endmodule

// File: hdl/ddp_qdiv.sv
// pipelined saturating fixed point divide, floor(num * 2^frac / den)
// restoring, one quotient bit per stage; depends on ddp_pkg
module ddp_qdiv #(
  parameter int unsigned DATA_WIDTH = ddp_pkg::DDP_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = ddp_pkg::DDP_FRAC_BITS,
  parameter int unsigned ROOT_W     = (DATA_WIDTH + FRAC_BITS + 1) / 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [DATA_WIDTH-1:0] num_i,
  input  logic [ROOT_W-1:0]     den_i,
  output logic                  valid_o,
  output logic [DATA_WIDTH-1:0] quo_o,
  output logic [ROOT_W-1:0]     den_o
);
  import ddp_pkg::*;

  localparam int unsigned W       = DATA_WIDTH;
  localparam int unsigned NUM_STG = W + 1;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [W-1:0]      lo;
    logic [W-1:0]      q;
    logic [ROOT_W-1:0] d;
    logic              sat;
    logic              zro;
  } div_st_t;

  logic    v_q  [NUM_STG];
  div_st_t st_q [NUM_STG];

  for (genvar i = 0; i < NUM_STG; i++) begin : g_stg
    logic    v_in;
    div_st_t st_d;

    if (i == 0) begin : g_first
      logic [W+FRAC_BITS-1:0] ext;
      logic [FRAC_BITS-1:0]   hi;

      // overflow check on the top bits, then seed the remainder
      assign v_in = valid_i;
      assign ext  = {num_i, {FRAC_BITS{1'b0}}};
      assign hi   = ext[W+FRAC_BITS-1:W];
      always_comb begin
        st_d.rem = ROOT_W'(hi);
        st_d.lo  = ext[W-1:0];
        st_d.q   = '0;
        st_d.d   = den_i;
        st_d.zro = (den_i == '0) && (num_i == '0);
        st_d.sat = (den_i == '0) ? (num_i != '0) : (ROOT_W'(hi) >= den_i);
      end
    end else begin : g_step
      logic [ROOT_W:0] r2;

      // shift in one dividend bit, subtract when it fits
      assign v_in = v_q[i-1];
      assign r2   = {st_q[i-1].rem, st_q[i-1].lo[W-1]};
      always_comb begin
        st_d    = st_q[i-1];
        st_d.lo = st_q[i-1].lo << 1;
        if (r2 >= {1'b0, st_q[i-1].d}) begin
          st_d.rem = ROOT_W'(r2 - {1'b0, st_q[i-1].d});
          st_d.q   = {st_q[i-1].q[W-2:0], 1'b1};
        end else begin
          st_d.rem = r2[ROOT_W-1:0];
          st_d.q   = {st_q[i-1].q[W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i] <= st_d;
      end
    end
  end

  // zero over zero gives zero, overflow saturates
  assign valid_o = v_q[NUM_STG-1];
  assign den_o   = st_q[NUM_STG-1].d;
  assign quo_o   = st_q[NUM_STG-1].zro ? '0 :
                   st_q[NUM_STG-1].sat ? '1 : st_q[NUM_STG-1].q;

endmodule

// File: hdl/ddp_term.sv
// one dipole source term: distance, exponential falloff and three divides
// depends on ddp_pkg, ddp_isqrt, ddp_exp and ddp_qdiv
module ddp_term #(
  parameter int unsigned DATA_WIDTH = ddp_pkg::DDP_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = ddp_pkg::DDP_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [DATA_WIDTH-1:0] r2_i,
  input  logic [DATA_WIDTH-1:0] depth_i,
  input  logic [DATA_WIDTH-1:0] coeff_i,
  output logic                  valid_o,
  output logic [DATA_WIDTH-1:0] term_o
);
  import ddp_pkg::*;

  localparam int unsigned W      = DATA_WIDTH;
  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned ROOT_W = (W + F + 1) / 2;
  localparam int unsigned PW     = 2 * W;
  localparam int unsigned SW     = W + ROOT_W;
  localparam int unsigned GW     = W + EXP_BITS + 1;
  localparam int unsigned SBW    = W + ROOT_W;

  localparam logic [W-1:0] MAXV  = '1;
  localparam logic [W:0]   ONE_X = {{W{1'b0}}, 1'b1} << F;

  // depth squared
  logic [PW-1:0] zz_prod;
  logic [PW-1:0] zz_shr;
  logic [W-1:0]  z2_d;
  logic          v1_q;
  logic [W-1:0]  r2_q;
  logic [W-1:0]  z2_q;

  assign zz_prod = PW'(depth_i) * PW'(depth_i);
  assign zz_shr  = zz_prod >> F;
  assign z2_d    = (|zz_shr[PW-1:W]) ? MAXV : zz_shr[W-1:0];

  // squared distance to the source
  logic [W:0]   s2_sum;
  logic [W-1:0] s2_d;
  logic         v2_q;
  logic [W-1:0] s2_q;

  assign s2_sum = {1'b0, r2_q} + {1'b0, z2_q};
  assign s2_d   = s2_sum[W] ? MAXV : s2_sum[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r2_q <= r2_i;
      z2_q <= z2_d;
      s2_q <= s2_d;
    end
  end

  // distance
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;

  ddp_isqrt #(
    .DATA_WIDTH (W),
    .FRAC_BITS  (F),
    .ROOT_W     (ROOT_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v2_q),
    .rad_i   (s2_q),
    .valid_o (sq_valid),
    .root_o  (sq_root)
  );

  // sigma times distance
  logic [SW-1:0]     sd_prod;
  logic [SW-1:0]     sd_shr;
  logic [W-1:0]      sd_d;
  logic              v3_q;
  logic [W-1:0]      sd_q;
  logic [ROOT_W-1:0] d3_q;

  assign sd_prod = SW'(coeff_i) * SW'(sq_root);
  assign sd_shr  = sd_prod >> F;
  assign sd_d    = (|sd_shr[SW-1:W]) ? MAXV : sd_shr[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q <= sd_d;
      d3_q <= sq_root;
    end
  end

  // exponential, with sigma*d + 1 and d carried alongside
  logic [W:0]        sp1_sum;
  logic [W-1:0]      sp1;
  logic              ex_valid;
  exp_val_t          ex_val;
  logic [SBW-1:0]    ex_sb;
  logic [W-1:0]      sp1_e;
  logic [ROOT_W-1:0] d_e;

  assign sp1_sum = {1'b0, sd_q} + ONE_X;
  assign sp1     = sp1_sum[W] ? MAXV : sp1_sum[W-1:0];

  ddp_exp #(
    .DATA_WIDTH (W),
    .FRAC_BITS  (F),
    .SB_WIDTH   (SBW)
  ) u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v3_q),
    .arg_i   (sd_q),
    .sb_i    ({sp1, d3_q}),
    .valid_o (ex_valid),
    .exp_o   (ex_val),
    .sb_o    (ex_sb)
  );

  assign sp1_e = ex_sb[SBW-1:ROOT_W];
  assign d_e   = ex_sb[ROOT_W-1:0];

  // g = (sigma*d + 1) * exp, then a = z * g
  logic [GW-1:0]     g_prod;
  logic [GW-1:0]     g_shr;
  logic [W-1:0]      g_d;
  logic              v5_q;
  logic [W-1:0]      g_q;
  logic [ROOT_W-1:0] d5_q;
  logic [PW-1:0]     a_prod;
  logic [PW-1:0]     a_shr;
  logic [W-1:0]      a_d;
  logic              v6_q;
  logic [W-1:0]      a_q;
  logic [ROOT_W-1:0] d6_q;

  assign g_prod = GW'(sp1_e) * GW'(ex_val);
  assign g_shr  = g_prod >> EXP_BITS;
  assign g_d    = (|g_shr[GW-1:W]) ? MAXV : g_shr[W-1:0];
  assign a_prod = PW'(depth_i) * PW'(g_q);
  assign a_shr  = a_prod >> F;
  assign a_d    = (|a_shr[PW-1:W]) ? MAXV : a_shr[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= ex_valid;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g_q  <= g_d;
      d5_q <= d_e;
      a_q  <= a_d;
      d6_q <= d5_q;
    end
  end

  // divide by d three times
  logic              div_v [DDP_NUM_DIV+1];
  logic [W-1:0]      div_n [DDP_NUM_DIV+1];
  logic [ROOT_W-1:0] div_d [DDP_NUM_DIV+1];

  assign div_v[0] = v6_q;
  assign div_n[0] = a_q;
  assign div_d[0] = d6_q;

  for (genvar k = 0; k < DDP_NUM_DIV; k++) begin : g_div
    ddp_qdiv #(
      .DATA_WIDTH (W),
      .FRAC_BITS  (F),
      .ROOT_W     (ROOT_W)
    ) u_qdiv (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (div_v[k]),
      .num_i   (div_n[k]),
      .den_i   (div_d[k]),
      .valid_o (div_v[k+1]),
      .quo_o   (div_n[k+1]),
      .den_o   (div_d[k+1])
    );
  end

  assign valid_o = div_v[DDP_NUM_DIV];
  assign term_o  = div_n[DDP_NUM_DIV];

endmodule
